// ===== hw/rtl/world_point_to_local_polar_defines.svh =====
// ----------------------------------------------------------------------------
// World point to local polar: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WORLD_POINT_TO_LOCAL_POLAR_DEFINES_SVH
`define WORLD_POINT_TO_LOCAL_POLAR_DEFINES_SVH

// Plain property on the block clock.
`define WPOLAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define WPOLAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wpolar_pkg.sv =====
// ----------------------------------------------------------------------------
// World point to local polar: package
// Widths, register codes, CORDIC angle table and gain constant.
// ----------------------------------------------------------------------------
package wpolar_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int EFF_STEPS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int STEP_W       = (EFF_STEPS > 1) ? $clog2(EFF_STEPS) : 1;

  localparam int COORD_W  = 32;
  localparam int ROT_W    = 16;
  localparam int ROT_FRAC = 14;
  localparam int ANGLE_W  = 32;
  localparam int BEAR_W   = 16;
  localparam int RANGE_W  = 32;

  // Rotated products, their sum and the local point after translation.
  localparam int PROD_W = ROT_W + COORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int LW     = SUM_W - ROT_FRAC + 1;
  // CORDIC datapath: local point scaled by the guard bits plus growth margin.
  localparam int CW     = LW + FRAC_BITS + 4;
  localparam int HI_W   = CW - 32;
  localparam int T_W    = CW + 1;
  localparam int TP_W   = T_W + 1;
  localparam int RF_W   = TP_W - FRAC_BITS;

  // APB register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROT_00  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROT_01  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROT_10  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROT_11  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;

  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [ANGLE_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Reciprocal of the CORDIC gain in unsigned Q0.32 for a given step count.
  function automatic logic [31:0] gain_inv(int steps);
    int unsigned sh;
    logic [63:0] g;
    sh = 2 * steps;
    g  = 64'd2608131497;
    if (sh >= 1 && sh < 40) begin
      g = g + ((64'd1738754331 + (64'd1 << (sh - 1))) >> sh);
    end
    return g[31:0];
  endfunction

  localparam logic [31:0] GAIN_INV = gain_inv(EFF_STEPS);

  typedef struct packed {
    logic signed [ROT_W-1:0]   rot_00;
    logic signed [ROT_W-1:0]   rot_01;
    logic signed [ROT_W-1:0]   rot_10;
    logic signed [ROT_W-1:0]   rot_11;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] shift_y;
  } pose_t;

  typedef struct packed {
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic [ANGLE_W-1:0]    z;
    logic                  zero;
  } cordic_t;

endpackage

// ===== hw/rtl/wpolar_in_if.sv =====
// ----------------------------------------------------------------------------
// World point to local polar: point channel
// Valid/ready channel carrying one world point per request.
// ----------------------------------------------------------------------------
interface wpolar_in_if;
  import wpolar_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

// ===== hw/rtl/wpolar_out_if.sv =====
// ----------------------------------------------------------------------------
// World point to local polar: polar channel
// Valid/ready channel carrying bearing, range and the saturation flag.
// ----------------------------------------------------------------------------
interface wpolar_out_if;
  import wpolar_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [BEAR_W-1:0]  bearing;
  logic [RANGE_W-1:0]        range;
  logic                      range_clipped;

  modport source (output valid, bearing, range, range_clipped, input ready);
  modport sink (input valid, bearing, range, range_clipped, output ready);
endinterface

// ===== hw/rtl/wpolar_xform.sv =====
// ----------------------------------------------------------------------------
// World point to local polar: pose transform
// Three stages: rotation products, sum/round/translate, CORDIC preparation.
// ----------------------------------------------------------------------------
module wpolar_xform (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [wpolar_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [wpolar_pkg::COORD_W-1:0] point_y_i,
  input  wpolar_pkg::pose_t                  pose_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output wpolar_pkg::cordic_t                data_o
);
  import wpolar_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (ROT_FRAC - 1);

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_rdy, s2_rdy, s3_rdy;

  logic signed [PROD_W-1:0] p00_q, p10_q, p01_q, p11_q;
  logic signed [PROD_W-1:0] p00_d, p10_d, p01_d, p11_d;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [LW-1:0]     lx_q, ly_q, lx_d, ly_d;
  logic signed [CW-1:0]     xs, ys;
  cordic_t                  prep_d, prep_q;

  assign s3_rdy  = !s3_v_q || ready_i;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign ready_o = s1_rdy;

  // Stage 1: products of the point with the transposed rotation.
  always_comb begin
    p00_d = PROD_W'($signed(pose_i.rot_00)) * PROD_W'(point_x_i);
    p10_d = PROD_W'($signed(pose_i.rot_10)) * PROD_W'(point_y_i);
    p01_d = PROD_W'($signed(pose_i.rot_01)) * PROD_W'(point_x_i);
    p11_d = PROD_W'($signed(pose_i.rot_11)) * PROD_W'(point_y_i);
  end

  // Stage 2: round half up back to Q16.16 and take off the translation.
  always_comb begin
    sum_x = SUM_W'(p00_q) + SUM_W'(p10_q) + ROUND_HALF;
    sum_y = SUM_W'(p01_q) + SUM_W'(p11_q) + ROUND_HALF;
    lx_d  = LW'(sum_x >>> ROT_FRAC) - LW'($signed(pose_i.shift_x));
    ly_d  = LW'(sum_y >>> ROT_FRAC) - LW'($signed(pose_i.shift_y));
  end

  // Stage 3: scale by the guard bits and fold the left half plane over.
  always_comb begin
    xs = CW'(lx_q) <<< FRAC_BITS;
    ys = CW'(ly_q) <<< FRAC_BITS;
    prep_d.zero = (lx_q == '0) && (ly_q == '0);
    if (lx_q[LW-1]) begin
      prep_d.x = -xs;
      prep_d.y = -ys;
      prep_d.z = HALF_TURN;
    end else begin
      prep_d.x = xs;
      prep_d.y = ys;
      prep_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s1_rdy) begin
      p00_q <= p00_d;
      p10_q <= p10_d;
      p01_q <= p01_d;
      p11_q <= p11_d;
    end
    if (s1_v_q && s2_rdy) begin
      lx_q <= lx_d;
      ly_q <= ly_d;
    end
    if (s2_v_q && s3_rdy) begin
      prep_q <= prep_d;
    end
  end

  assign valid_o = s3_v_q;
  assign data_o  = prep_q;
endmodule

// ===== hw/rtl/wpolar_cell.sv =====
// ----------------------------------------------------------------------------
// World point to local polar: CORDIC cell
// One vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module wpolar_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [wpolar_pkg::STEP_W-1:0]       step_i,
  input  logic [wpolar_pkg::ANGLE_W-1:0]      atan_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  wpolar_pkg::cordic_t                 data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output wpolar_pkg::cordic_t                 data_o
);
  import wpolar_pkg::*;

  logic                 v_q;
  cordic_t              data_d, data_q;
  logic signed [CW-1:0] dx, dy;

  assign ready_o = !v_q || ready_i;

  // Drive y towards zero; the step index and angle are tied off per cell.
  always_comb begin
    dx          = $signed(data_i.y) >>> step_i;
    dy          = $signed(data_i.x) >>> step_i;
    data_d.zero = data_i.zero;
    if (!data_i.y[CW-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + atan_i;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;
endmodule

// ===== hw/rtl/wpolar_gain.sv =====
// ----------------------------------------------------------------------------
// World point to local polar: gain and output stage
// Gain compensation multiply, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module wpolar_gain (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  wpolar_pkg::cordic_t                 data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [wpolar_pkg::BEAR_W-1:0] bearing_o,
  output logic [wpolar_pkg::RANGE_W-1:0]      range_o,
  output logic                                range_clipped_o
);
  import wpolar_pkg::*;

  localparam logic [TP_W-1:0]    RANGE_HALF = TP_W'(1) << (FRAC_BITS - 1);
  localparam logic [ANGLE_W-1:0] BEAR_HALF  = ANGLE_W'(1) << (ANGLE_W - BEAR_W - 1);

  logic m_v_q, o_v_q;
  logic m_rdy, o_rdy;

  logic [CW-1:0]      p_hi_d, p_hi_q;
  logic [63:0]        p_lo_d, p_lo_q;
  logic [ANGLE_W-1:0] z_q;
  logic               zero_q;

  logic [T_W-1:0]           t_sum;
  logic [RF_W-1:0]          rng_full;
  logic [ANGLE_W-1:0]       z_rnd;
  logic                     clip_d;
  logic signed [BEAR_W-1:0] bear_d, bear_q;
  logic [RANGE_W-1:0]       rng_d, rng_q;
  logic                     clip_q;

  assign o_rdy   = !o_v_q || ready_i;
  assign m_rdy   = !m_v_q || o_rdy;
  assign ready_o = m_rdy;

  // x is non-negative after vectoring, so it splits into unsigned halves.
  always_comb begin
    p_hi_d = CW'(data_i.x[CW-1:32]) * CW'(GAIN_INV);
    p_lo_d = 64'(data_i.x[31:0]) * 64'(GAIN_INV);
  end

  always_comb begin
    t_sum    = T_W'(p_hi_q) + T_W'(p_lo_q[63:32]);
    rng_full = RF_W'((TP_W'(t_sum) + RANGE_HALF) >> FRAC_BITS);
    clip_d   = |rng_full[RF_W-1:RANGE_W];
    z_rnd    = z_q + BEAR_HALF;
    if (zero_q) begin
      bear_d = '0;
      rng_d  = '0;
      clip_d = 1'b0;
    end else begin
      bear_d = $signed(z_rnd[ANGLE_W-1:ANGLE_W-BEAR_W]);
      rng_d  = clip_d ? '1 : rng_full[RANGE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (m_rdy) m_v_q <= valid_i;
      if (o_rdy) o_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && m_rdy) begin
      p_hi_q <= p_hi_d;
      p_lo_q <= p_lo_d;
      z_q    <= data_i.z;
      zero_q <= data_i.zero;
    end
    if (m_v_q && o_rdy) begin
      bear_q <= bear_d;
      rng_q  <= rng_d;
      clip_q <= clip_d;
    end
  end

  assign valid_o         = o_v_q;
  assign bearing_o       = bear_q;
  assign range_o         = rng_q;
  assign range_clipped_o = clip_q;
endmodule

// ===== hw/rtl/world_point_to_local_polar.sv =====
// Throughput: one point per cycle while the output is not stalled; every stage and CORDIC cell has its own register.
// Each stage holds while full and stalled, so empty stages keep taking requests.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the identity pose.
// ----------------------------------------------------------------------------
// World point to local polar: top level
// Pose registers on APB, pose transform, CORDIC cell chain and gain stage.
// ----------------------------------------------------------------------------
`include "world_point_to_local_polar_defines.svh"

module world_point_to_local_polar (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  wpolar_in_if.sink                          point_i,
  wpolar_out_if.source                       polar_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wpolar_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import wpolar_pkg::*;

  logic [ROT_W-1:0]     rot00_q, rot01_q, rot10_q, rot11_q;
  logic [COORD_W-1:0]   shx_q, shy_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  pose_t                pose;

  cordic_t                 chain_data [EFF_STEPS+1];
  logic [EFF_STEPS:0]      chain_valid;
  logic [EFF_STEPS:0]      chain_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot00_q <= ROT_W'(16384);
      rot01_q <= '0;
      rot10_q <= '0;
      rot11_q <= ROT_W'(16384);
      shx_q   <= '0;
      shy_q   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROT_00:  rot00_q <= pwdata[ROT_W-1:0];
        REG_ROT_01:  rot01_q <= pwdata[ROT_W-1:0];
        REG_ROT_10:  rot10_q <= pwdata[ROT_W-1:0];
        REG_ROT_11:  rot11_q <= pwdata[ROT_W-1:0];
        REG_SHIFT_X: shx_q   <= pwdata;
        REG_SHIFT_Y: shy_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROT_00:  prdata = 32'(rot00_q);
      REG_ROT_01:  prdata = 32'(rot01_q);
      REG_ROT_10:  prdata = 32'(rot10_q);
      REG_ROT_11:  prdata = 32'(rot11_q);
      REG_SHIFT_X: prdata = shx_q;
      REG_SHIFT_Y: prdata = shy_q;
      default:     prdata = '0;
    endcase
  end

  assign pose.rot_00  = rot00_q;
  assign pose.rot_01  = rot01_q;
  assign pose.rot_10  = rot10_q;
  assign pose.rot_11  = rot11_q;
  assign pose.shift_x = shx_q;
  assign pose.shift_y = shy_q;

  wpolar_xform u_xform (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (point_i.valid),
    .ready_o   (point_i.ready),
    .point_x_i (point_i.point_x),
    .point_y_i (point_i.point_y),
    .pose_i    (pose),
    .valid_o   (chain_valid[0]),
    .ready_i   (chain_ready[0]),
    .data_o    (chain_data[0])
  );

  for (genvar k = 0; k < EFF_STEPS; k++) begin : g_cell
    wpolar_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(k)),
      .atan_i  (ATAN_TAB[k]),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  wpolar_gain u_gain (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (chain_valid[EFF_STEPS]),
    .ready_o         (chain_ready[EFF_STEPS]),
    .data_i          (chain_data[EFF_STEPS]),
    .valid_o         (polar_o.valid),
    .ready_i         (polar_o.ready),
    .bearing_o       (polar_o.bearing),
    .range_o         (polar_o.range),
    .range_clipped_o (polar_o.range_clipped)
  );

  // A saturated range must read as all ones.
  `WPOLAR_ASSERT(a_clip_all_ones, !(polar_o.valid && polar_o.range_clipped) || (polar_o.range == '1), "clipped range is not all ones")

  // With the output register empty every stage can advance, so the input is ready to take a point.
  `WPOLAR_ASSERT(a_ready_when_drained, polar_o.valid || point_i.ready, "point refused while pipeline drained")

  // A rotation write lands in its register on the completing edge.
  `WPOLAR_ASSERT_NEXT(a_rot00_write, wr_en && (reg_idx == REG_ROT_00), rot00_q == $past(pwdata[ROT_W-1:0]), "rot_00 write lost")

  // A translation write lands in its register on the completing edge.
  `WPOLAR_ASSERT_NEXT(a_shx_write, wr_en && (reg_idx == REG_SHIFT_X), shx_q == $past(pwdata), "shift_x write lost")
endmodule
